// ===== src/eds_pkg.sv =====
package eds_pkg;

	localparam int DIST_W    = 10;
	localparam int CFG_IDX_W = 2;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_ECHO_VALUE = 2'd2;

	localparam logic [DIST_W-1:0] LOWER_LIMIT_RST   = 10'd5;
	localparam logic [DIST_W-1:0] UPPER_LIMIT_RST   = 10'd500;
	localparam logic [DIST_W-1:0] NO_ECHO_VALUE_RST = 10'd550;

	// func codes of an input word
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_ECHO = 1'b1;

	// raw = floor(t * 17 / 500) + 3. At t >= 30000 raw reaches 1023 and can never
	// be inside the window, so only 15 bits of t go through the multiplier.
	localparam int SMALL_W     = 15;
	localparam int TICK_LIMIT  = 30000;
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 24;
	localparam logic [RECIP_W-1:0] RECIP_MULT = 20'd570426;  // ceil(17 * 2^24 / 500)
	localparam logic [DIST_W-1:0]  RAW_OFFSET = 10'd3;

	typedef struct packed {
		logic func;
		logic echo_level;
	} eds_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_cm;
		logic              in_window;
	} eds_out_t;

	typedef struct packed {
		logic [DIST_W-1:0] lower_limit;
		logic [DIST_W-1:0] upper_limit;
		logic [DIST_W-1:0] no_echo_value;
	} eds_cfg_t;

endpackage

// ===== src/eds_timer.sv =====
module eds_timer #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_accept,
	input  eds_pkg::eds_in_t         in_word,
	input  logic                     load,
	output logic                     valid_s1,
	output logic [COUNTER_WIDTH-1:0] width_s1
);
	import eds_pkg::*;

	logic [COUNTER_WIDTH-1:0] count_q;
	logic [COUNTER_WIDTH-1:0] latched_q;
	logic                     running_q;
	logic                     is_echo;

	assign is_echo = in_accept && (in_word.func == FUNC_ECHO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			latched_q <= '0;
			running_q <= 1'b0;
		end else if (in_accept) begin
			if (in_word.func == FUNC_TICK) begin
				if (running_q && (count_q != '1)) begin
					count_q <= count_q + COUNTER_WIDTH'(1);
				end
			end else if (in_word.echo_level) begin
				count_q   <= '0;
				running_q <= 1'b1;
			end else begin
				latched_q <= count_q;
				count_q   <= '0;
				running_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= is_echo;
		end
	end

	// width the filter sees: the freshly latched count on a falling edge,
	// the stale one on a rising edge
	always_ff @(posedge clk) begin
		if (load && is_echo) begin
			width_s1 <= in_word.echo_level ? latched_q : count_q;
		end
	end

endmodule

// ===== src/eds_range.sv =====
module eds_range #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic                             valid_s1,
	input  logic [COUNTER_WIDTH-1:0]         width_s1,
	output logic                             valid_s2,
	output logic                             far_s2,
	output logic [eds_pkg::DIST_W-1:0]       quot_s2
);
	import eds_pkg::*;

	localparam int TW     = (COUNTER_WIDTH > SMALL_W) ? COUNTER_WIDTH : SMALL_W;
	localparam int PROD_W = SMALL_W + RECIP_W;

	logic [TW-1:0]      width_ext;
	logic [SMALL_W-1:0] width_small;
	logic               far;
	logic [PROD_W-1:0]  prod;

	assign width_ext   = TW'(width_s1);
	assign far         = width_ext >= TW'(TICK_LIMIT);
	assign width_small = width_ext[SMALL_W-1:0];
	// floor(t * 17 / 500) by reciprocal, exact for t below the limit
	assign prod        = PROD_W'(width_small) * PROD_W'(RECIP_MULT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_s1) begin
			far_s2  <= far;
			quot_s2 <= prod[RECIP_SHIFT +: DIST_W];
		end
	end

endmodule

// ===== src/eds_filter.sv =====
module eds_filter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic                       valid_s2,
	input  logic                       far_s2,
	input  logic [eds_pkg::DIST_W-1:0] quot_s2,
	input  eds_pkg::eds_cfg_t          cfg,
	output logic                       out_valid,
	output eds_pkg::eds_out_t          out_word
);
	import eds_pkg::*;

	// the oldest history entry drops out of the mean, so only two are kept
	logic [DIST_W-1:0]   cur_q;
	logic                win_q;
	logic [DIST_W-1:0]   hist_q [2];
	logic [DIST_W-1:0]   raw;
	logic                ok;
	logic [DIST_W+1:0]   sum;

	assign raw = quot_s2 + RAW_OFFSET;
	assign ok  = !far_s2 && (raw > cfg.lower_limit) && (raw < cfg.upper_limit);
	assign sum = (DIST_W+2)'(raw) + (DIST_W+2)'(cur_q)
	           + (DIST_W+2)'(hist_q[0]) + (DIST_W+2)'(hist_q[1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			cur_q     <= '0;
			win_q     <= 1'b0;
			hist_q[0] <= '0;
			hist_q[1] <= '0;
		end else if (load) begin
			out_valid <= valid_s2;
			if (valid_s2) begin
				win_q <= ok;
				if (ok) begin
					hist_q[1] <= hist_q[0];
					hist_q[0] <= cur_q;
					cur_q     <= sum[DIST_W+1:2];
				end else begin
					cur_q <= cfg.no_echo_value;
				end
			end
		end
	end

	assign out_word.distance_cm = cur_q;
	assign out_word.in_window   = win_q;

endmodule

// ===== src/echo_pulse_distance_smoother_core.sv =====
// Ultrasonic echo ranger with a four-point moving average. Tick words (func 0)
// advance the pulse timer and give no result; echo words (func 1) give one
// result each. A new word can follow every cycle while in_ready is high. An
// echo word's result passes three registers: one holds the latched width, one
// the reciprocal product that stands in for the divide by 500, and the output
// register holds the filter state. A stalled output backs up into those
// stages, so in_ready drops only once all three hold an unfinished word.
// Limits may be changed only while idle.
module echo_pulse_distance_smoother_core #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  eds_pkg::eds_in_t                     in_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output eds_pkg::eds_out_t                    out_word,
	input  logic                                 cfg_wr_en,
	input  logic [eds_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [eds_pkg::DIST_W-1:0]           cfg_data
);
	import eds_pkg::*;

	eds_cfg_t                 cfg_q;
	logic                     valid_s1;
	logic [COUNTER_WIDTH-1:0] width_s1;
	logic                     valid_s2;
	logic                     far_s2;
	logic [DIST_W-1:0]        quot_s2;
	logic                     go1;
	logic                     go2;
	logic                     go3;

	assign go3      = !out_valid || out_ready;
	assign go2      = !valid_s2 || go3;
	assign go1      = !valid_s1 || go2;
	assign in_ready = go1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lower_limit   <= LOWER_LIMIT_RST;
			cfg_q.upper_limit   <= UPPER_LIMIT_RST;
			cfg_q.no_echo_value <= NO_ECHO_VALUE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LOWER_LIMIT:   cfg_q.lower_limit   <= cfg_data;
				REG_UPPER_LIMIT:   cfg_q.upper_limit   <= cfg_data;
				REG_NO_ECHO_VALUE: cfg_q.no_echo_value <= cfg_data;
				default: ;
			endcase
		end
	end

	eds_timer #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_valid && in_ready),
		.in_word   (in_word),
		.load      (go1),
		.valid_s1  (valid_s1),
		.width_s1  (width_s1)
	);

	eds_range #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_range (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go2),
		.valid_s1 (valid_s1),
		.width_s1 (width_s1),
		.valid_s2 (valid_s2),
		.far_s2   (far_s2),
		.quot_s2  (quot_s2)
	);

	eds_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go3),
		.valid_s2  (valid_s2),
		.far_s2    (far_s2),
		.quot_s2   (quot_s2),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

endmodule

// ===== src/eds_checker.sv =====
module eds_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input eds_pkg::eds_in_t              in_word,
	input logic                          out_valid,
	input logic                          out_ready,
	input eds_pkg::eds_out_t             out_word,
	input logic                          cfg_wr_en,
	input logic [eds_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [eds_pkg::DIST_W-1:0]    cfg_data
);
	import eds_pkg::*;

	logic [DIST_W-1:0] no_echo_q;
	logic [2:0]        pending_q;
	logic              echo_in;
	logic              word_out;

	assign echo_in  = in_valid && in_ready && (in_word.func == FUNC_ECHO);
	assign word_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_echo_q <= NO_ECHO_VALUE_RST;
			pending_q <= '0;
		end else begin
			if (cfg_wr_en && (cfg_index == REG_NO_ECHO_VALUE)) begin
				no_echo_q <= cfg_data;
			end
			pending_q <= pending_q + {2'b0, echo_in} - {2'b0, word_out};
		end
	end

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// out-of-window result carries the no-echo value
	a_no_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.in_window |-> out_word.distance_cm == no_echo_q)
		else $error("out-of-window word without no-echo value");

	// every result word belongs to an earlier echo word
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		word_out |-> pending_q != 3'd0)
		else $error("result word without an echo word");

	// no more echo words in flight than the pipeline holds
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("too many echo words in flight");

endmodule

bind echo_pulse_distance_smoother_core eds_checker u_eds_checker (.*);

// ===== tb/testbench.sv =====
module testbench;
	import eds_pkg::*;

	localparam int CNT_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it
	localparam int SINK_HOLD = 80;
	localparam int SETTLE = 8;
	localparam int PHASE_WORDS = 240;
	localparam int PHASE_RESULTS = 15;

	class distance_scoreboard;
		logic [DIST_W-1:0] lower_lim, upper_lim, no_echo;
		logic [CNT_W-1:0]  ticks, held_width;
		bit                timing;
		logic [DIST_W-1:0] shown_dist;
		logic [DIST_W-1:0] prev_dist [3];
		eds_out_t          expected_q [$];
		int                errors;
		int                results;

		function new();
			lower_lim = LOWER_LIMIT_RST;
			upper_lim = UPPER_LIMIT_RST;
			no_echo = NO_ECHO_VALUE_RST;
			ticks = '0;
			held_width = '0;
			timing = 1'b0;
			shown_dist = '0;
			foreach (prev_dist[i]) prev_dist[i] = '0;
			errors = 0;
			results = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
			case (idx)
				REG_LOWER_LIMIT: lower_lim = data;
				REG_UPPER_LIMIT: upper_lim = data;
				REG_NO_ECHO_VALUE: no_echo = data;
				default: ;
			endcase
		endfunction

		function void note_word(eds_in_t w);
			int unsigned raw;
			int unsigned sum;
			eds_out_t exp_w;
			if (w.func == FUNC_TICK) begin
				if (timing && ticks != '1) ticks++;
				return;
			end
			if (w.echo_level) begin
				ticks = '0;
				timing = 1'b1;
			end else begin
				held_width = ticks;
				ticks = '0;
				timing = 1'b0;
			end
			// filter runs on every edge, even a rising one with a stale width
			raw = 32'(held_width);
			raw = (raw * 170 / 1000) / 5 + 3;
			exp_w.in_window = (raw > 32'(lower_lim)) && (raw < 32'(upper_lim));
			if (exp_w.in_window) begin
				prev_dist[2] = prev_dist[1];
				prev_dist[1] = prev_dist[0];
				prev_dist[0] = shown_dist;
				sum = raw + 32'(prev_dist[0]) + 32'(prev_dist[1]) + 32'(prev_dist[2]);
				shown_dist = DIST_W'(sum / 4);
			end else begin
				shown_dist = no_echo;
			end
			exp_w.distance_cm = shown_dist;
			expected_q.push_back(exp_w);
		endfunction

		function void check_word(eds_out_t w);
			eds_out_t exp_w;
			if (expected_q.size() == 0) begin
				$error("unexpected word: distance_cm %0d in_window %0d",
					w.distance_cm, w.in_window);
				errors++;
				return;
			end
			exp_w = expected_q.pop_front();
			results++;
			if (w.distance_cm !== exp_w.distance_cm) begin
				$error("distance_cm: expected %0d, got %0d", exp_w.distance_cm, w.distance_cm);
				errors++;
			end
			if (w.in_window !== exp_w.in_window) begin
				$error("in_window: expected %0d, got %0d", exp_w.in_window, w.in_window);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	eds_in_t                in_word;
	logic                   out_valid;
	logic                   out_ready;
	eds_out_t               out_word;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [DIST_W-1:0]      cfg_data;

	distance_scoreboard sb;
	int words_sent = 0;
	bit burst = 1'b0;      // sender skips its gaps
	bit hold_sink = 1'b0;  // receiver holds off for a long stretch

	echo_pulse_distance_smoother_core #(
		.COUNTER_WIDTH(CNT_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) sb.set_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) sb.note_word(in_word);
			if (out_valid && out_ready) sb.check_word(out_word);
		end
	end

	// receiver
	initial begin
		int gap;
		bit steady;
		steady = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_sink) begin
				out_ready <= 1'b0;
				repeat (SINK_HOLD) @(negedge clk);
				hold_sink = 1'b0;
			end
			if ($urandom_range(0, 39) == 0) steady = !steady;
			gap = steady ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	task automatic send_word(input logic f, input logic lvl);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		// ticks while the timer is stopped are dropped by the block
		if (f == FUNC_ECHO || sb.timing) words_sent++;
		in_valid <= 1'b1;
		in_word <= '{func: f, echo_level: lvl};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic pulse(input int len);
		send_word(FUNC_ECHO, 1'b1);
		repeat (len) send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
		send_word(FUNC_ECHO, 1'b0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic load_limits(input logic [DIST_W-1:0] lo, hi, ne);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_LOWER_LIMIT;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= REG_UPPER_LIMIT;
		cfg_data <= hi;
		@(negedge clk);
		cfg_index <= REG_NO_ECHO_VALUE;
		cfg_data <= ne;
		@(negedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= DIST_W'($urandom);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic int pulse_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(0, 20);
		if (r < 98) return $urandom_range(21, 300);
		return $urandom_range(301, 2000);
	endfunction

	task automatic run_phase(input logic [DIST_W-1:0] lo, hi, ne);
		int start_words;
		int start_results;
		int pick;
		drain();
		load_limits(lo, hi, ne);
		start_words = words_sent;
		start_results = sb.results;
		while (words_sent - start_words < PHASE_WORDS
				|| sb.results - start_results < PHASE_RESULTS) begin
			burst = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				pulse(pulse_len());
			end else if (pick < 90) begin
				send_word(FUNC_ECHO, 1'($urandom_range(0, 1)));
			end else if (pick < 95) begin
				send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
			end else begin
				// pulse cut short: no falling edge
				send_word(FUNC_ECHO, 1'b1);
				repeat ($urandom_range(0, 10)) send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
			end
		end
		burst = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ticks while stopped, edges with stale and cleared widths, restart
		send_word(FUNC_TICK, 1'b0);
		send_word(FUNC_TICK, 1'b1);
		send_word(FUNC_ECHO, 1'b0);
		send_word(FUNC_ECHO, 1'b1);
		send_word(FUNC_TICK, 1'b1);
		send_word(FUNC_TICK, 1'b0);
		send_word(FUNC_TICK, 1'b1);
		send_word(FUNC_ECHO, 1'b1);
		repeat (3) send_word(FUNC_TICK, 1'b0);
		send_word(FUNC_ECHO, 1'b0);
		drain();
		load_limits(10'd0, 10'd1023, 10'd1023);
		send_word(FUNC_ECHO, 1'b1);
		repeat (2) send_word(FUNC_TICK, 1'b1);
		send_word(FUNC_ECHO, 1'b0);
		send_word(FUNC_ECHO, 1'b0);
		send_word(FUNC_ECHO, 1'b1);
		send_word(FUNC_ECHO, 1'b0);

		run_phase(LOWER_LIMIT_RST, UPPER_LIMIT_RST, NO_ECHO_VALUE_RST);
		// widths around the lower window edge at reset limits
		pulse(88);
		pulse(89);

		run_phase(10'd0, 10'd1023, 10'd0);
		drain();
		// fill the block against a stalled receiver
		hold_sink = 1'b1;
		burst = 1'b1;
		repeat (16) send_word(FUNC_ECHO, 1'($urandom_range(0, 1)));
		burst = 1'b0;
		drain();
		repeat (4) pulse(pulse_len());

		run_phase(10'd1023, 10'd0, 10'd1023);
		run_phase(10'd2, 10'd12, DIST_W'($urandom));
		// raw 11 and 12 around the upper window edge
		pulse(264);
		pulse(265);
		run_phase(DIST_W'($urandom_range(0, 10)), DIST_W'($urandom_range(4, 40)),
			DIST_W'($urandom));

		drain();
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
